[hdl/assert_macros.svh]
// Assertion macros used by the top level of the I2C byte sequencer.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("assertion failed: implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rstn, cond, cons)
`define ASSERT_NEXT(label, clk, rstn, cond, cons)

`endif

`endif

[hdl/i2cms_pkg.sv]
// Shared types, codes and constants of the I2C byte sequencer.
// Depends on nothing; imported by every module of the block.
package i2cms_pkg;

    localparam int CMD_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 7;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int BIT_CNT_W    = 4;
    localparam int BITS_PER_BYTE = 8;

    localparam int DELAY_WIDTH_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Command codes on the input word
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ADDR  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_SETUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COND_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_PHASE  = 2'd3;

    localparam logic [CFG_W-1:0] EDGE_SETUP_RST = 8'd4;
    localparam logic [CFG_W-1:0] COND_HOLD_RST  = 8'd40;
    localparam logic [CFG_W-1:0] BIT_PHASE_RST  = 8'd10;
    localparam logic [CFG_W-1:0] ACK_PHASE_RST  = 8'd50;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_NONE,
        K_START,
        K_STOP,
        K_WRITE,
        K_READ,
        K_ADDR,
        K_OTHER
    } cmd_kind_t;

    // One queued tick
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] load_byte;
        logic              sda_in;
    } tick_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] received_byte;
        logic              ack_seen;
        logic              rejected;
    } result_t;

endpackage

[hdl/i2cms_front.sv]
// Front end: input register stage that classifies commands and forms the load byte.
// Depends on i2cms_pkg; feeds i2cms_queue.
module i2cms_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2cms_pkg::CMD_W-1:0]   s_cmd,
    input  logic [i2cms_pkg::BYTE_W-1:0]  s_write_byte,
    input  logic [i2cms_pkg::ADDR_W-1:0]  s_target_address,
    input  logic                          s_read_flag,
    input  logic                          s_sda_in,
    input  logic                          q_full,
    output logic                          q_push,
    output i2cms_pkg::tick_entry_t        q_entry
);
    import i2cms_pkg::*;

    logic        hold_valid_reg;
    logic        hold_valid_next;
    tick_entry_t hold_entry_reg;
    tick_entry_t decoded;

    always_comb begin
        case (s_cmd)
            CMD_TICK:  decoded.kind = K_NONE;
            CMD_START: decoded.kind = K_START;
            CMD_STOP:  decoded.kind = K_STOP;
            CMD_WRITE: decoded.kind = K_WRITE;
            CMD_READ:  decoded.kind = K_READ;
            CMD_ADDR:  decoded.kind = K_ADDR;
            default:   decoded.kind = K_OTHER;
        endcase
        decoded.load_byte = (s_cmd == CMD_ADDR) ? {s_target_address, s_read_flag}
                                                : s_write_byte;
        decoded.sda_in    = s_sda_in;
    end

    assign s_ready  = !hold_valid_reg || !q_full;
    assign q_push   = hold_valid_reg && !q_full;
    assign q_entry  = hold_entry_reg;

    assign hold_valid_next = s_ready ? s_valid : hold_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            hold_entry_reg <= decoded;
        end
    end

endmodule

[hdl/i2cms_queue.sv]
// Short FIFO of classified ticks between the front end and the sequencer.
// Depends on i2cms_pkg.
module i2cms_queue #(
    parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  i2cms_pkg::tick_entry_t  push_entry,
    input  logic                    pop,
    output i2cms_pkg::tick_entry_t  head_entry,
    output i2cms_pkg::queue_status_t status
);
    import i2cms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tick_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_entry   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hdl/i2cms_back.sv]
// Back end: bus sequencer retiring one tick per cycle unless the queue is empty
// or m_ready stalls; config and output regs. Uses i2cms_pkg; fed by i2cms_queue.
module i2cms_back #(
    parameter int DELAY_WIDTH = i2cms_pkg::DELAY_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cms_pkg::CFG_W-1:0]    cfg_wdata,
    input  i2cms_pkg::queue_status_t       q_status,
    input  i2cms_pkg::tick_entry_t         q_head,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output i2cms_pkg::result_t             m_result
);
    import i2cms_pkg::*;

    localparam int DW = DELAY_WIDTH;
    localparam int EW = DW + CFG_W;
    localparam logic [EW-1:0] DELAY_MAX = EW'({DW{1'b1}});

    typedef enum logic [4:0] {
        P_IDLE = 5'd0,
        P_S0   = 5'd1,  P_S1  = 5'd2,  P_S2  = 5'd3,  P_S3  = 5'd4,
        P_P0   = 5'd5,  P_P1  = 5'd6,  P_P2  = 5'd7,  P_P3  = 5'd8,
        P_W0   = 5'd9,  P_W1  = 5'd10, P_W2  = 5'd11,
        P_WA0  = 5'd12, P_WA1 = 5'd13, P_WA2 = 5'd14,
        P_R0   = 5'd15, P_R1  = 5'd16, P_R2  = 5'd17, P_R3  = 5'd18,
        P_RA0  = 5'd19, P_RA1 = 5'd20, P_RA2 = 5'd21, P_RA3 = 5'd22
    } phase_t;

    // Configuration
    logic [CFG_W-1:0] edge_setup_reg, cond_hold_reg, bit_phase_reg, ack_phase_reg;

    // Sequencer state
    phase_t               phase_reg, phase_next;
    logic [DW-1:0]        tick_reg, tick_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 ack_reg, ack_next;
    logic [BYTE_W-1:0]    last_read_reg, last_read_next;
    logic                 rej, done;

    logic                 m_valid_reg, m_valid_next;
    result_t              m_result_reg;

    logic [DW-1:0] d_setup, d_hold, d_bit, d_ack;

    function automatic logic [DW-1:0] sat_delay(input logic [CFG_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > DELAY_MAX) ? {DW{1'b1}} : DW'(ext);
    endfunction

    assign d_setup = sat_delay(edge_setup_reg);
    assign d_hold  = sat_delay(cond_hold_reg);
    assign d_bit   = sat_delay(bit_phase_reg);
    assign d_ack   = sat_delay(ack_phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_setup_reg <= EDGE_SETUP_RST;
            cond_hold_reg  <= COND_HOLD_RST;
            bit_phase_reg  <= BIT_PHASE_RST;
            ack_phase_reg  <= ACK_PHASE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_EDGE_SETUP: edge_setup_reg <= cfg_wdata;
                REG_COND_HOLD:  cond_hold_reg  <= cfg_wdata;
                REG_BIT_PHASE:  bit_phase_reg  <= cfg_wdata;
                REG_ACK_PHASE:  ack_phase_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Retire a tick when one is queued and the output register frees up
    assign q_pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        last_read_next = last_read_reg;
        rej            = 1'b0;
        done           = 1'b0;

        if (phase_reg != P_IDLE) begin
            rej = (q_head.kind != K_NONE);
        end else begin
            case (q_head.kind)
                K_START: begin
                    phase_next = P_S0;
                    tick_next  = '0;
                    bit_next   = '0;
                end
                K_STOP: begin
                    phase_next = P_P0;
                    tick_next  = '0;
                    bit_next   = '0;
                end
                K_READ: begin
                    phase_next = P_R0;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                end
                K_WRITE, K_ADDR: begin
                    phase_next = P_W0;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = q_head.load_byte;
                end
                default: ;
            endcase
        end

        if (phase_next != P_IDLE) begin
            if (tick_next != '0) begin
                tick_next = tick_next - 1'b1;
            end else begin
                case (phase_next)
                    P_S0:  begin sda_next = 1'b1; tick_next = d_setup; phase_next = P_S1; end
                    P_S1:  begin scl_next = 1'b1; tick_next = d_hold;  phase_next = P_S2; end
                    P_S2:  begin sda_next = 1'b0; tick_next = d_hold;  phase_next = P_S3; end
                    P_S3: begin
                        scl_next   = 1'b0;
                        tick_next  = '0;
                        phase_next = P_IDLE;
                        done       = 1'b1;
                    end
                    P_P0:  begin sda_next = 1'b0; tick_next = d_setup; phase_next = P_P1; end
                    P_P1:  begin scl_next = 1'b1; tick_next = d_hold;  phase_next = P_P2; end
                    P_P2:  begin sda_next = 1'b1; tick_next = d_hold;  phase_next = P_P3; end
                    P_P3: begin
                        tick_next  = '0;
                        phase_next = P_IDLE;
                        done       = 1'b1;
                    end
                    P_W0: begin
                        sda_next   = shift_next[BYTE_W-1];
                        tick_next  = d_bit;
                        phase_next = P_W1;
                    end
                    P_W1:  begin scl_next = 1'b1; tick_next = d_bit; phase_next = P_W2; end
                    P_W2: begin
                        scl_next   = 1'b0;
                        shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                        bit_next   = bit_next + 1'b1;
                        tick_next  = d_bit;
                        phase_next = (bit_next >= BIT_CNT_W'(BITS_PER_BYTE)) ? P_WA0 : P_W0;
                    end
                    P_WA0: begin tick_next = d_ack; phase_next = P_WA1; end
                    P_WA1: begin scl_next = 1'b1; tick_next = d_ack; phase_next = P_WA2; end
                    P_WA2: begin
                        sda_next   = 1'b1;
                        ack_next   = q_head.sda_in;
                        scl_next   = 1'b0;
                        tick_next  = '0;
                        phase_next = P_IDLE;
                        done       = 1'b1;
                    end
                    P_R0:  begin tick_next = d_bit; phase_next = P_R1; end
                    P_R1:  begin scl_next = 1'b1; tick_next = d_bit; phase_next = P_R2; end
                    P_R2:  begin scl_next = 1'b0; tick_next = d_bit; phase_next = P_R3; end
                    P_R3: begin
                        sda_next   = 1'b1;
                        shift_next = {shift_next[BYTE_W-2:0], q_head.sda_in};
                        bit_next   = bit_next + 1'b1;
                        tick_next  = '0;
                        phase_next = (bit_next >= BIT_CNT_W'(BITS_PER_BYTE)) ? P_RA0 : P_R0;
                    end
                    P_RA0: begin sda_next = 1'b0; tick_next = d_bit; phase_next = P_RA1; end
                    P_RA1: begin scl_next = 1'b1; tick_next = d_bit; phase_next = P_RA2; end
                    P_RA2: begin scl_next = 1'b0; tick_next = d_bit; phase_next = P_RA3; end
                    P_RA3: begin
                        last_read_next = shift_next;
                        tick_next      = '0;
                        phase_next     = P_IDLE;
                        done           = 1'b1;
                    end
                    default: begin
                        tick_next  = '0;
                        phase_next = P_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= P_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            last_read_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                last_read_reg <= last_read_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_result_reg.scl_level     <= scl_next;
            m_result_reg.sda_level     <= sda_next;
            m_result_reg.busy_res      <= (phase_next != P_IDLE);
            m_result_reg.done_res      <= done;
            m_result_reg.received_byte <= last_read_next;
            m_result_reg.ack_seen      <= ack_next;
            m_result_reg.rejected      <= rej;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

[hdl/i2c_master_byte_sequencer_top.sv]
// Top level of the tick-driven I2C master byte sequencer.
// Depends on i2cms_pkg, assert_macros.svh, i2cms_front, i2cms_queue, i2cms_back.
//
// Usage:
//   Each input word on the s_ channel is one bus time tick. It carries a command
//   (tick only, start, stop, write byte, read byte, address) and the SDA level
//   sampled on that tick. Every accepted word yields exactly one result word on
//   the m_ channel: the SCL/SDA levels to drive, busy/done flags, the last read
//   byte, the last acknowledge sample, and a reject flag for a command that
//   arrived while a sequence was still running.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) sets the four delay
//   registers; write it only while no word is in flight and the bus is idle.
//   Path: an accepted word passes the front register, then a queue entry, then
//   the sequencer output register before its result word is valid on m_.
//   Throughput: one word per cycle while m_ready does not stall, as the back
//   end retires one queued tick on each sequencer update.
//   The queue between front and back lets a stalled m_ready back up through the
//   queue and front register before s_ready drops; no word is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline, parks the bus with
//   SCL low and SDA released, and restores the delay registers to defaults.
module i2c_master_byte_sequencer_top #(
    parameter int DELAY_WIDTH = i2cms_pkg::DELAY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cms_pkg::CFG_W-1:0]     cfg_wdata,
    // Tick input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [i2cms_pkg::CMD_W-1:0]     s_cmd,
    input  logic [i2cms_pkg::BYTE_W-1:0]    s_write_byte,
    input  logic [i2cms_pkg::ADDR_W-1:0]    s_target_address,
    input  logic                            s_read_flag,
    input  logic                            s_sda_in,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_scl_level,
    output logic                            m_sda_level,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [i2cms_pkg::BYTE_W-1:0]    m_received_byte,
    output logic                            m_ack_seen,
    output logic                            m_rejected
);
    import i2cms_pkg::*;

`include "assert_macros.svh"

    logic          q_push;
    logic          q_pop;
    tick_entry_t   q_in_entry;
    tick_entry_t   q_head;
    queue_status_t q_status;
    result_t       result;

    // Accept and classify ticks
    i2cms_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_write_byte     (s_write_byte),
        .s_target_address (s_target_address),
        .s_read_flag      (s_read_flag),
        .s_sda_in         (s_sda_in),
        .q_full           (q_status.full),
        .q_push           (q_push),
        .q_entry          (q_in_entry)
    );

    // Decouple front and back
    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .status     (q_status)
    );

    // Sequence the bus one tick at a time
    i2cms_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_scl_level     = result.scl_level;
    assign m_sda_level     = result.sda_level;
    assign m_busy_res      = result.busy_res;
    assign m_done_res      = result.done_res;
    assign m_received_byte = result.received_byte;
    assign m_ack_seen      = result.ack_seen;
    assign m_rejected      = result.rejected;

    // A completing tick always leaves the sequencer idle
    `ASSERT_IMPLIES(a_done_means_idle, aclk, aresetn, m_valid && m_done_res, !m_busy_res)
    // Never push into a full queue
    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, q_push, !q_status.full)
    // Never pop an empty queue
    `ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, q_pop, !q_status.empty)
    // A retired tick always shows up as a valid result next cycle
    `ASSERT_NEXT(a_pop_gives_result, aclk, aresetn, q_pop, m_valid)

endmodule
